@@ hw/rtl/ir_range_median_calibrate_assert.svh @@
// assertion macros used by the range median calibrator rtl
`ifndef IR_RANGE_MEDIAN_CALIBRATE_ASSERT_SVH
`define IR_RANGE_MEDIAN_CALIBRATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define IRC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("irc assertion failed");
`define IRC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("irc forbidden condition");
`else
`define IRC_ASSERT(lbl, clk, rstn, prop)
`define IRC_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ hw/rtl/irc_pkg.sv @@
// shared types, constants and tables of the range median calibrator
`timescale 1ns / 1ps
package irc_pkg;

    localparam int BURST_SAMPLES = 11;
    localparam int CNT_W         = $clog2(BURST_SAMPLES);
    localparam int MED_IDX       = (BURST_SAMPLES - 1) / 2;
    localparam int SAMPLE_W      = 10;
    localparam int DIST_W        = 23;
    localparam int D_W           = 24;
    localparam int OFF_W         = 14;
    localparam int PROF_W        = 3;

    localparam logic [D_W-1:0] DIST_MAX = 24'd2300000;

    // short range curve
    localparam logic [SAMPLE_W-1:0] X_MIN      = 10'd10;
    localparam logic [SAMPLE_W-1:0] X_BIAS     = 10'd3;
    localparam int                  DIV_NUM_W  = 20;
    localparam int                  DIV_DEN_W  = 10;
    localparam int                  DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam logic [DIV_NUM_W-1:0] SHORT_NUM = 20'd678700;
    localparam logic signed [D_W-1:0] SHORT_SUB = 24'sd400;

    // 10/13 scale: ceil(2^24 / 13), exact for numerators below 2^20
    localparam int                  SCALE_W      = 21;
    localparam int                  SCALE_SHIFT  = 24;
    localparam int                  SCALE_FULL_W = DIV_NUM_W + SCALE_W;
    localparam logic [SCALE_W-1:0]  SCALE_RECIP  = 21'd1290556;

    // log2 unit
    localparam int LOG_IN_W  = 22;
    localparam int LOG_IP_W  = 5;
    localparam int LOG_FR_W  = 16;
    localparam int LOG_W     = LOG_IP_W + LOG_FR_W;
    localparam int MANT_W    = 31;
    localparam int LOG_CNT_W = $clog2(LOG_FR_W);
    localparam int FIT_W     = 27;

    localparam logic [PROF_W-1:0] PROF_SCALED = 3'd1;
    localparam logic [PROF_W-1:0] PROF_LONG   = 3'd5;
    localparam logic [PROF_W-1:0] PROF_RESET  = 3'd6;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_MEDIAN,
        S_DIV1,
        S_SCALE,
        S_LOG_T,
        S_LOG_HI,
        S_SEARCH_GO,
        S_SEARCH_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                gt;
    } cell_link_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                start;
        logic [LOG_IN_W-1:0] n;
    } log_req_t;

    // same squaring log2 as the hardware unit, used at elaboration only
    function automatic logic [LOG_W-1:0] log2_q16(input logic [31:0] n);
        logic [LOG_IP_W-1:0] ip;
        logic [63:0]         m;
        logic [LOG_FR_W-1:0] fr;
        ip = '0;
        fr = '0;
        for (int b = 0; b < 32; b++) begin
            if (n[b]) ip = LOG_IP_W'(b);
        end
        m = 64'(n) << (6'd30 - 6'(ip));
        for (int i = 0; i < LOG_FR_W; i++) begin
            m  = (m * m) >> 30;
            fr = {fr[LOG_FR_W-2:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                m     = m >> 1;
                fr[0] = 1'b1;
            end
        end
        return {ip, fr};
    endfunction

    localparam logic [FIT_W-1:0] LOG_RHS =
        FIT_W'(10) * FIT_W'(log2_q16(32'd6500)) + FIT_W'(110 * 65536);

    // piecewise offset per profile, first threshold above d wins
    function automatic logic signed [OFF_W-1:0] seg_offset(
        input logic [PROF_W-1:0]   p,
        input logic signed [D_W-1:0] d
    );
        logic signed [OFF_W-1:0] o;
        o = '0;
        case (p)
            3'd0: begin
                if      (d < 24'sd1750) o = -14'sd500;
                else if (d < 24'sd3000) o = -14'sd700;
                else if (d < 24'sd3750) o = -14'sd800;
                else if (d < 24'sd4200) o = 14'sd0;
                else if (d < 24'sd4500) o = 14'sd800;
                else                    o = 14'sd0;
            end
            3'd1: begin
                if      (d < 24'sd1500) o = -14'sd308;
                else if (d < 24'sd2800) o = -14'sd385;
                else if (d < 24'sd4000) o = -14'sd615;
                else if (d < 24'sd6000) o = -14'sd1769;
                else                    o = 14'sd3000;
            end
            3'd2: begin
                if      (d < 24'sd2000) o = -14'sd500;
                else if (d < 24'sd3500) o = -14'sd800;
                else if (d < 24'sd4500) o = -14'sd1100;
                else if (d < 24'sd5500) o = -14'sd700;
                else if (d < 24'sd7500) o = -14'sd1700;
                else                    o = 14'sd0;
            end
            3'd3: begin
                if      (d < 24'sd1500) o = -14'sd200;
                else if (d < 24'sd4700) o = -14'sd500;
                else                    o = 14'sd0;
            end
            3'd4: begin
                if      (d < 24'sd1850) o = 14'sd100;
                else if (d < 24'sd3100) o = -14'sd200;
                else if (d < 24'sd4300) o = -14'sd500;
                else if (d < 24'sd5500) o = -14'sd800;
                else if (d < 24'sd6700) o = -14'sd1300;
                else                    o = 14'sd0;
            end
            3'd5: begin
                if      (d < 24'sd2400) o = -14'sd1100;
                else if (d < 24'sd4000) o = -14'sd700;
                else if (d < 24'sd5200) o = -14'sd900;
                else if (d < 24'sd6300) o = -14'sd1100;
                else if (d < 24'sd7600) o = -14'sd1400;
                else if (d < 24'sd8800) o = -14'sd1500;
                else                    o = 14'sd0;
            end
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

@@ hw/rtl/irc_cell.sv @@
// one cell of the insertion sorting row
`timescale 1ns / 1ps
module irc_cell (
    input  logic                          clk,
    input  logic                          shift_en,
    input  logic [irc_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          occupied,
    input  irc_pkg::cell_link_t           left,
    output irc_pkg::cell_link_t           link
);

    logic [irc_pkg::SAMPLE_W-1:0] val_reg;
    logic [irc_pkg::SAMPLE_W-1:0] val_next;
    logic                         gt;

    // an empty cell counts as larger than anything
    assign gt = !occupied || (val_reg > sample);

    always_comb
    begin
        val_next = val_reg;
        if (shift_en && gt)
        begin
            val_next = left.gt ? left.val : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.val = val_reg;
    assign link.gt  = gt;

endmodule

@@ hw/rtl/irc_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module irc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  irc_pkg::div_req_t              req,
    output logic                           done,
    output logic [irc_pkg::DIV_NUM_W-1:0]  quo
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [irc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [irc_pkg::DIV_NUM_W-1:0]   q_reg;
    logic [irc_pkg::DIV_DEN_W-1:0]   r_reg;
    logic [irc_pkg::DIV_DEN_W-1:0]   den_reg;
    logic [irc_pkg::DIV_DEN_W:0]     r_sh;
    logic [irc_pkg::DIV_DEN_W:0]     r_sub;
    logic                            qbit;

    assign r_sh  = {r_reg, q_reg[irc_pkg::DIV_NUM_W-1]};
    assign qbit  = r_sh >= {1'b0, den_reg};
    assign r_sub = qbit ? (r_sh - {1'b0, den_reg}) : r_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == irc_pkg::DIV_CNT_W'(irc_pkg::DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.num;
            r_reg   <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[irc_pkg::DIV_NUM_W-2:0], qbit};
            r_reg <= r_sub[irc_pkg::DIV_DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

@@ hw/rtl/irc_log2.sv @@
// log2 in q16, fraction by repeated squaring of the mantissa
`timescale 1ns / 1ps
module irc_log2 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  irc_pkg::log_req_t           req,
    output logic                        done,
    output logic [irc_pkg::LOG_W-1:0]   result
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [irc_pkg::LOG_CNT_W-1:0]   cnt_reg;
    logic [irc_pkg::MANT_W-1:0]      m_reg;
    logic [irc_pkg::LOG_IP_W-1:0]    ip_reg;
    logic [irc_pkg::LOG_FR_W-1:0]    fr_reg;
    logic [irc_pkg::LOG_IP_W-1:0]    ip_new;
    logic [irc_pkg::MANT_W-1:0]      m_init;
    logic [2*irc_pkg::MANT_W-1:0]    prod;
    logic [irc_pkg::MANT_W:0]        sq;

    // top set bit of the operand
    always_comb
    begin
        ip_new = '0;
        for (int b = 0; b < irc_pkg::LOG_IN_W; b++)
        begin
            if (req.n[b]) ip_new = irc_pkg::LOG_IP_W'(b);
        end
    end

    assign m_init = {{(irc_pkg::MANT_W - irc_pkg::LOG_IN_W){1'b0}}, req.n}
                    << (irc_pkg::LOG_IP_W'(irc_pkg::MANT_W - 1) - ip_new);
    assign prod   = m_reg * m_reg;
    assign sq     = prod[2*irc_pkg::MANT_W-1:irc_pkg::MANT_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == irc_pkg::LOG_CNT_W'(irc_pkg::LOG_FR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            m_reg  <= m_init;
            ip_reg <= ip_new;
            fr_reg <= '0;
        end
        else if (busy_reg)
        begin
            fr_reg <= {fr_reg[irc_pkg::LOG_FR_W-2:0], sq[irc_pkg::MANT_W]};
            m_reg  <= sq[irc_pkg::MANT_W] ? sq[irc_pkg::MANT_W:1]
                                          : sq[irc_pkg::MANT_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = {ip_reg, fr_reg};

endmodule

@@ hw/rtl/ir_range_median_calibrate.sv @@
// top level: burst median of range samples and distance calibration
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------
//  sample in | start, busy            | adc_sample
//  config    | cfg_valid, cfg_ready   | cfg_data (sensor profile)
//  result    | result_valid (strobe)  | distance_centi_cm, median_raw
//
// a row of sorting cells inserts each sample beat in place
// after the last sample of a burst the block is busy; the bit-serial divider, with the
// 10/13 scale after it, sets the busy time on short range, and the 16-step log2
// unit in the search sets it on long range
// reset: profile 6, empty burst, no result pending; cells are not cleared
// results are a one-cycle strobe; the receiver cannot stall them
`timescale 1ns / 1ps
`include "ir_range_median_calibrate_assert.svh"
module ir_range_median_calibrate (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [irc_pkg::SAMPLE_W-1:0]         adc_sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [irc_pkg::PROF_W-1:0]           cfg_data,
    output logic                                 result_valid,
    output logic signed [irc_pkg::DIST_W-1:0]    distance_centi_cm,
    output logic [irc_pkg::SAMPLE_W-1:0]         median_raw
);

    irc_pkg::state_t                    state_reg;
    irc_pkg::state_t                    state_next;
    logic [irc_pkg::CNT_W-1:0]          cnt_reg;
    logic [irc_pkg::PROF_W-1:0]         cfg_reg;
    logic                               strobe_reg;

    logic [irc_pkg::PROF_W-1:0]         prof_reg;
    logic [irc_pkg::SAMPLE_W-1:0]       med_reg;
    logic [irc_pkg::FIT_W-1:0]          lhs_reg;
    logic [irc_pkg::LOG_IN_W-1:0]       lo_reg;
    logic [irc_pkg::LOG_IN_W-1:0]       hi_reg;
    logic signed [irc_pkg::D_W-1:0]     d_reg;
    logic signed [irc_pkg::DIST_W-1:0]  dist_reg;
    logic [irc_pkg::SAMPLE_W-1:0]       med_out_reg;

    logic                               accept;
    logic                               burst_end;
    irc_pkg::cell_link_t                links [irc_pkg::BURST_SAMPLES];
    logic [irc_pkg::SAMPLE_W-1:0]       med_val;

    irc_pkg::div_req_t                  div_req;
    logic                               div_done;
    logic [irc_pkg::DIV_NUM_W-1:0]      div_quo;
    irc_pkg::log_req_t                  log_req;
    logic                               log_done;
    logic [irc_pkg::LOG_W-1:0]          log_res;

    logic [irc_pkg::SAMPLE_W-1:0]       x_clamp;
    logic [irc_pkg::DIV_DEN_W-1:0]      den_s;
    logic [irc_pkg::DIV_NUM_W-1:0]      num_s;
    logic signed [irc_pkg::D_W-1:0]     quo_adj;
    logic signed [irc_pkg::D_W-1:0]     scale_prod;
    logic [irc_pkg::SCALE_FULL_W-1:0]   scale_full;
    logic [irc_pkg::FIT_W-1:0]          fit_sum;
    logic                               fits;
    logic [irc_pkg::LOG_IN_W-1:0]       mid;
    logic [irc_pkg::LOG_IN_W-1:0]       gap_next;
    logic signed [irc_pkg::D_W-1:0]     d_sum;
    logic signed [irc_pkg::D_W-1:0]     d_clamp;

    assign busy      = state_reg != irc_pkg::S_COLLECT;
    assign accept    = start && !busy;
    assign burst_end = accept && (cnt_reg == irc_pkg::CNT_W'(irc_pkg::BURST_SAMPLES - 1));
    assign cfg_ready = !busy;

    // sorting row: each cell keeps one sample in order, takes its left
    // neighbor's value when the new sample lands to its left
    for (genvar i = 0; i < irc_pkg::BURST_SAMPLES; i++)
    begin : g_cell
        irc_pkg::cell_link_t left_link;
        if (i == 0)
        begin : g_head
            assign left_link = '0;
        end
        else
        begin : g_body
            assign left_link = links[i-1];
        end
        irc_cell u_cell (
            .clk      (clk),
            .shift_en (accept),
            .sample   (adc_sample),
            .occupied (irc_pkg::CNT_W'(i) < cnt_reg),
            .left     (left_link),
            .link     (links[i])
        );
    end

    assign med_val = links[irc_pkg::MED_IDX].val;

    // short range operands: clamp, then rounded reciprocal
    assign x_clamp = (med_val < irc_pkg::X_MIN) ? irc_pkg::X_MIN : med_val;
    assign den_s   = x_clamp - irc_pkg::X_BIAS;
    assign num_s   = irc_pkg::SHORT_NUM
                     + {{(irc_pkg::DIV_NUM_W - irc_pkg::DIV_DEN_W + 1){1'b0}},
                        den_s[irc_pkg::DIV_DEN_W-1:1]};
    assign quo_adj = irc_pkg::D_W'(signed'({1'b0, div_quo})) - irc_pkg::SHORT_SUB;
    // 10/13 scale with round to nearest, value is never negative here
    // the divide by 13 is a multiply by the scaled reciprocal
    assign scale_prod = d_reg * irc_pkg::D_W'(10) + irc_pkg::D_W'(6);
    assign scale_full = irc_pkg::SCALE_FULL_W'(scale_prod[irc_pkg::DIV_NUM_W-1:0])
                        * irc_pkg::SCALE_FULL_W'(irc_pkg::SCALE_RECIP);

    // long range: largest distance whose log sum stays at or under the limit
    assign fit_sum = irc_pkg::FIT_W'(10) * irc_pkg::FIT_W'(log_res) + lhs_reg;
    assign fits    = fit_sum <= irc_pkg::LOG_RHS;
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign gap_next = fits ? (hi_reg - mid) : (mid - lo_reg);

    assign d_sum   = d_reg + irc_pkg::D_W'(irc_pkg::seg_offset(prof_reg, d_reg));
    assign d_clamp = (d_sum > signed'(irc_pkg::DIST_MAX)) ? signed'(irc_pkg::DIST_MAX)
                                                          : d_sum;

    irc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    irc_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (log_req),
        .done   (log_done),
        .result (log_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irc_pkg::S_COLLECT:
            begin
                if (burst_end) state_next = irc_pkg::S_MEDIAN;
            end
            irc_pkg::S_MEDIAN:
            begin
                if (cfg_reg != irc_pkg::PROF_LONG)
                    state_next = irc_pkg::S_DIV1;
                else if (med_val == '0)
                    state_next = irc_pkg::S_FINISH;
                else
                    state_next = irc_pkg::S_LOG_T;
            end
            irc_pkg::S_DIV1:
            begin
                if (div_done)
                    state_next = (prof_reg == irc_pkg::PROF_SCALED) ? irc_pkg::S_SCALE
                                                                    : irc_pkg::S_FINISH;
            end
            irc_pkg::S_SCALE:
            begin
                state_next = irc_pkg::S_FINISH;
            end
            irc_pkg::S_LOG_T:
            begin
                if (log_done) state_next = irc_pkg::S_LOG_HI;
            end
            irc_pkg::S_LOG_HI:
            begin
                if (log_done)
                    state_next = fits ? irc_pkg::S_FINISH : irc_pkg::S_SEARCH_GO;
            end
            irc_pkg::S_SEARCH_GO:
            begin
                state_next = irc_pkg::S_SEARCH_WAIT;
            end
            irc_pkg::S_SEARCH_WAIT:
            begin
                if (log_done)
                    state_next = (gap_next > irc_pkg::LOG_IN_W'(1)) ? irc_pkg::S_SEARCH_GO
                                                                     : irc_pkg::S_FINISH;
            end
            irc_pkg::S_FINISH:
            begin
                state_next = irc_pkg::S_COLLECT;
            end
            default:
            begin
                state_next = irc_pkg::S_COLLECT;
            end
        endcase
    end

    // unit requests
    always_comb
    begin
        div_req = '0;
        log_req = '0;
        case (state_reg)
            irc_pkg::S_MEDIAN:
            begin
                if (cfg_reg != irc_pkg::PROF_LONG)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = num_s;
                    div_req.den   = den_s;
                end
                else if (med_val != '0)
                begin
                    log_req.start = 1'b1;
                    log_req.n     = irc_pkg::LOG_IN_W'(med_val) * irc_pkg::LOG_IN_W'(5);
                end
            end
            irc_pkg::S_LOG_T:
            begin
                if (log_done)
                begin
                    log_req.start = 1'b1;
                    log_req.n     = irc_pkg::DIST_MAX[irc_pkg::LOG_IN_W-1:0];
                end
            end
            irc_pkg::S_SEARCH_GO:
            begin
                log_req.start = 1'b1;
                log_req.n     = mid;
            end
            default:
            begin
                div_req = '0;
                log_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= irc_pkg::S_COLLECT;
            cnt_reg    <= '0;
            cfg_reg    <= irc_pkg::PROF_RESET;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= state_reg == irc_pkg::S_FINISH;
            if (cfg_valid && cfg_ready) cfg_reg <= cfg_data;
            if (burst_end)
                cnt_reg <= '0;
            else if (accept)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            irc_pkg::S_MEDIAN:
            begin
                med_reg  <= med_val;
                prof_reg <= cfg_reg;
                d_reg    <= signed'(irc_pkg::DIST_MAX);
            end
            irc_pkg::S_DIV1:
            begin
                if (div_done) d_reg <= quo_adj;
            end
            irc_pkg::S_SCALE:
            begin
                d_reg <= irc_pkg::D_W'(
                    scale_full[irc_pkg::SCALE_FULL_W-1:irc_pkg::SCALE_SHIFT]);
            end
            irc_pkg::S_LOG_T:
            begin
                if (log_done) lhs_reg <= irc_pkg::FIT_W'(11) * irc_pkg::FIT_W'(log_res);
            end
            irc_pkg::S_LOG_HI:
            begin
                if (log_done)
                begin
                    lo_reg <= '0;
                    hi_reg <= irc_pkg::DIST_MAX[irc_pkg::LOG_IN_W-1:0];
                end
            end
            irc_pkg::S_SEARCH_WAIT:
            begin
                if (log_done)
                begin
                    if (fits) lo_reg <= mid;
                    else      hi_reg <= mid;
                    d_reg <= irc_pkg::D_W'(signed'({1'b0, fits ? mid : lo_reg}));
                end
            end
            irc_pkg::S_FINISH:
            begin
                dist_reg    <= d_clamp[irc_pkg::DIST_W-1:0];
                med_out_reg <= med_reg;
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    assign result_valid      = strobe_reg;
    assign distance_centi_cm = dist_reg;
    assign median_raw        = med_out_reg;

    // the last sample of a burst always starts the calculation
    `IRC_ASSERT(a_burst_busy, clk, rst_n, burst_end |=> busy)
    // a result beat lasts exactly one cycle
    `IRC_ASSERT(a_one_beat, clk, rst_n, result_valid |=> !result_valid)
    // fill count stays inside the row
    `IRC_NEVER(a_cnt_range, clk, rst_n, cnt_reg > irc_pkg::CNT_W'(irc_pkg::BURST_SAMPLES - 1))
    // search bounds stay ordered
    `IRC_NEVER(a_search_order, clk, rst_n, state_reg == irc_pkg::S_SEARCH_WAIT && lo_reg >= hi_reg)

endmodule

@@ tb/tb.sv @@
// testbench of the range median calibrator: directed bursts, random bursts, predicted results
`timescale 1ns / 1ps
module tb;

    localparam int BURST     = irc_pkg::BURST_SAMPLES;
    localparam int WDOG_MAX  = 5000;
    localparam int SETTLE    = 500;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [irc_pkg::SAMPLE_W-1:0]        adc_sample = '0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [irc_pkg::PROF_W-1:0]          cfg_data = '0;
    logic                                result_valid;
    logic signed [irc_pkg::DIST_W-1:0]   distance_centi_cm;
    logic [irc_pkg::SAMPLE_W-1:0]        median_raw;

    typedef struct {
        logic signed [irc_pkg::DIST_W-1:0] dist_cc;
        logic [irc_pkg::SAMPLE_W-1:0]      med;
    } range_result_t;

    // directed burst: fill pattern, optional typed-in result
    typedef struct {
        logic [irc_pkg::PROF_W-1:0]        prof;
        bit                                ramp;
        logic [irc_pkg::SAMPLE_W-1:0]      fill;
        bit                                known;
        logic signed [irc_pkg::DIST_W-1:0] dist_cc;
        logic [irc_pkg::SAMPLE_W-1:0]      med;
    } burst_row_t;

    range_result_t                 pending_ranges[$];
    logic [irc_pkg::SAMPLE_W-1:0]  burst_buf[BURST];
    int                            burst_fill = 0;
    logic [irc_pkg::PROF_W-1:0]    cur_profile = irc_pkg::PROF_RESET;
    int                            errors = 0;
    int                            samples_sent = 0;
    int                            ranges_seen = 0;
    int                            quiet_cycles = 0;
    bit                            no_idle = 1'b0;

    // calibration segments per profile, first threshold above d wins
    int seg_n[8]       = '{5, 4, 5, 4, 5, 7, 0, 0};
    int seg_top[8][7]  = '{
        '{1750, 3000, 3750, 4200, 4500, 0, 0},
        '{1500, 2800, 4000, 6000, 0, 0, 0},
        '{2000, 3500, 4500, 5500, 7500, 0, 0},
        '{1500, 3000, 4000, 4700, 0, 0, 0},
        '{1850, 3100, 4300, 5500, 6700, 0, 0},
        '{2400, 3000, 4000, 5200, 6300, 7600, 8800},
        '{0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0}};
    int seg_adj[8][7]  = '{
        '{-500, -700, -800, 0, 800, 0, 0},
        '{-308, -385, -615, -1769, 0, 0, 0},
        '{-500, -800, -1100, -700, -1700, 0, 0},
        '{-200, -500, -500, -500, 0, 0, 0},
        '{100, -200, -500, -800, -1300, 0, 0},
        '{-1100, -700, -700, -900, -1100, -1400, -1500},
        '{0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0}};
    int tail_adj[8]    = '{0, 3000, 0, 0, 0, 0, 0, 0};

    ir_range_median_calibrate uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .adc_sample        (adc_sample),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .result_valid      (result_valid),
        .distance_centi_cm (distance_centi_cm),
        .median_raw        (median_raw)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // log2 in q16: top bit index, then one fraction bit per squaring of the mantissa
    function automatic longint unsigned log2_fix(int unsigned n);
        int unsigned       ip;
        longint unsigned   m;
        longint unsigned   fr;
        ip = 0;
        fr = 0;
        if (n == 0)
            return 0;
        for (int b = 0; b < 32; b++)
            if (n[b]) ip = b;
        m = longint'(n) << (30 - ip);
        for (int i = 0; i < 16; i++)
        begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000)
            begin
                m  = m >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(ip) << 16) | fr;
    endfunction

    function automatic bit power_law_ok(int unsigned d, longint unsigned lt, longint unsigned rhs);
        if (d == 0)
            return 1'b1;
        return 10 * log2_fix(d) + lt <= rhs;
    endfunction

    // long range: largest distance that still satisfies the power law bound
    function automatic int long_range_dist(int unsigned x);
        longint unsigned lt;
        longint unsigned rhs;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        lo = 0;
        hi = 2300000;
        if (x == 0)
            return 2300000;
        lt  = 11 * log2_fix(5 * x);
        rhs = 10 * log2_fix(6500) + 110 * 65536;
        if (power_law_ok(hi, lt, rhs))
            return 2300000;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (power_law_ok(mid, lt, rhs)) lo = mid;
            else hi = mid;
        end
        return int'(lo);
    endfunction

    function automatic int short_range_dist(int unsigned x);
        int unsigned den;
        if (x < 10)
            x = 10;
        den = x - 3;
        return int'((678700 + den / 2) / den) - 400;
    endfunction

    // median of the burst, then curve, scale and segment offset
    function automatic range_result_t predict_range(logic [irc_pkg::PROF_W-1:0] prof);
        int            srt[BURST];
        int            tmp;
        int            d;
        int            adj;
        range_result_t r;
        for (int i = 0; i < BURST; i++)
            srt[i] = int'(burst_buf[i]);
        for (int i = 1; i < BURST; i++)
            for (int j = i; j > 0 && srt[j-1] > srt[j]; j--)
            begin
                tmp      = srt[j];
                srt[j]   = srt[j-1];
                srt[j-1] = tmp;
            end
        r.med = irc_pkg::SAMPLE_W'(srt[(BURST - 1) / 2]);
        if (prof == irc_pkg::PROF_LONG)
            d = long_range_dist(r.med);
        else
        begin
            d = short_range_dist(r.med);
            if (prof == irc_pkg::PROF_SCALED)
                d = (d * 10 + 6) / 13;
        end
        adj = tail_adj[prof];
        for (int k = 0; k < seg_n[prof]; k++)
            if (d < seg_top[prof][k])
            begin
                adj = seg_adj[prof][k];
                break;
            end
        d = d + adj;
        if (d > 2300000)
            d = 2300000;
        r.dist_cc = d[irc_pkg::DIST_W-1:0];
        return r;
    endfunction

    // one sample beat: hold start until the block takes it
    task automatic send_sample(logic [irc_pkg::SAMPLE_W-1:0] v);
        start      <= 1'b1;
        adc_sample <= v;
        do @(posedge clk); while (busy);
        samples_sent++;
        burst_buf[burst_fill] = v;
        burst_fill++;
        if (burst_fill == BURST)
        begin
            burst_fill = 0;
            pending_ranges.push_back(predict_range(cur_profile));
        end
    endtask

    task automatic maybe_gap();
        int n;
        if (no_idle || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 16);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // drain, let the block settle, then write the profile register
    task automatic write_profile(logic [irc_pkg::PROF_W-1:0] p);
        start <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_profile  = p;
    endtask

    function automatic logic [irc_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0:       return irc_pkg::SAMPLE_W'($urandom_range(0, 20));
            1:       return irc_pkg::SAMPLE_W'($urandom_range(1003, 1023));
            default: return irc_pkg::SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // result checker: every strobe must match the oldest predicted range
    always @(posedge clk)
    begin
        range_result_t want;
        if (rst_n && result_valid)
        begin
            ranges_seen++;
            if (pending_ranges.size() == 0)
            begin
                $display("%0t: unexpected result dist=%0d med=%0d",
                         $time, distance_centi_cm, median_raw);
                errors++;
            end
            else
            begin
                want = pending_ranges.pop_front();
                if (distance_centi_cm !== want.dist_cc)
                begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.dist_cc, distance_centi_cm);
                    errors++;
                end
                if (median_raw !== want.med)
                begin
                    $display("%0t: median expected %0d actual %0d",
                             $time, want.med, median_raw);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("timeout at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    burst_row_t directed[4] = '{
        '{irc_pkg::PROF_RESET, 1'b0, 10'd0,    1'b1, 23'sd96557,   10'd0},
        '{irc_pkg::PROF_RESET, 1'b0, 10'd1023, 1'b1, 23'sd265,     10'd1023},
        '{irc_pkg::PROF_LONG,  1'b0, 10'd0,    1'b1, 23'sd2300000, 10'd0},
        '{irc_pkg::PROF_LONG,  1'b1, 10'd1023, 1'b0, '0,           '0}};

    initial
    begin
        logic [irc_pkg::PROF_W-1:0] p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bursts; typed results are cross-checked against the predictor
        foreach (directed[r])
        begin
            if (directed[r].prof != cur_profile)
                write_profile(directed[r].prof);
            for (int i = 0; i < BURST; i++)
            begin
                send_sample(directed[r].ramp ? directed[r].fill - 10'(i * 100)
                                             : directed[r].fill);
                maybe_gap();
            end
            if (directed[r].known &&
                (pending_ranges[$].dist_cc !== directed[r].dist_cc ||
                 pending_ranges[$].med !== directed[r].med))
            begin
                $display("%0t: predictor row %0d expected %0d/%0d got %0d/%0d", $time, r,
                         directed[r].dist_cc, directed[r].med,
                         pending_ranges[$].dist_cc, pending_ranges[$].med);
                errors++;
            end
        end

        // random phases: every profile first, then random ones; no idling at the end
        for (int ph = 0; ph < 14; ph++)
        begin
            p = (ph < 8) ? irc_pkg::PROF_W'(ph) : irc_pkg::PROF_W'($urandom_range(0, 7));
            write_profile(p);
            no_idle = (ph >= 11);
            for (int b = 0; b < 5; b++)
                for (int i = 0; i < BURST; i++)
                begin
                    send_sample(random_sample());
                    maybe_gap();
                end
        end
        write_profile(irc_pkg::PROF_RESET);

        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d samples, %0d calibrated ranges over all eight profiles",
                 samples_sent, ranges_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
